>>> hdl/mbg_pkg.sv
package mbg_pkg;

  // Default grid capacity
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  // Width of the coordinate arithmetic; holds MAX + 2 for any capacity up to 256
  localparam int CMP_W = 10;

  // Item field widths
  localparam int OP_W     = 2;
  localparam int CELL_X_W = 7;
  localparam int CELL_Y_W = 6;
  localparam int SWAP_W   = 2;
  localparam int TRIED_W  = 3;

  // Configuration registers
  localparam int GW_W         = 8;
  localparam int GH_W         = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int RESET_WIDTH  = 80;
  localparam int RESET_HEIGHT = 24;

  // Stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_TRY,
    ST_CHECK,
    ST_MREAD,
    ST_MWRITE,
    ST_PUSH,
    ST_POP,
    ST_POPLD,
    ST_RDBIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_write;
    logic clr_open;
    logic start_init;
    logic shuffle;
    logic tried_inc;
    logic rd_target;
    logic wr_target;
    logic rd_mid;
    logic wr_mid;
    logic push;
    logic pop;
    logic load_top;
    logic set_wall;
    logic rd_cell;
    logic take_cell;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_last;
    logic depth_zero;
    logic need_shuffle;
    logic try_end;
    logic target_in;
    logic target_open;
    logic vertical;
    logic pop_more;
    logic read_border;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/mbg_ram.sv
module mbg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mbg_ctrl.sv
module mbg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mbg_pkg::dp_status_t status,
  output mbg_pkg::dp_cmd_t    cmd
);

  mbg_pkg::state_t state;
  mbg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbg_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbg_pkg::ST_INIT: begin
        if (status.clr_last) state_next = mbg_pkg::ST_IDLE;
      end
      mbg_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mbg_pkg::ST_DECODE;
      end
      mbg_pkg::ST_DECODE: begin
        unique case (status.op)
          mbg_pkg::OP_START: state_next = mbg_pkg::ST_CLEAR;
          mbg_pkg::OP_STEP: begin
            state_next = status.depth_zero ? mbg_pkg::ST_RESULT : mbg_pkg::ST_TRY;
          end
          mbg_pkg::OP_READ: begin
            state_next = status.read_border ? mbg_pkg::ST_RESULT : mbg_pkg::ST_RDBIT;
          end
          mbg_pkg::OP_NONE: state_next = mbg_pkg::ST_RESULT;
          default: state_next = mbg_pkg::ST_RESULT;
        endcase
      end
      mbg_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = mbg_pkg::ST_RESULT;
      end
      mbg_pkg::ST_TRY: begin
        if (status.try_end) begin
          state_next = mbg_pkg::ST_POP;
        end else if (status.target_in) begin
          state_next = mbg_pkg::ST_CHECK;
        end
      end
      mbg_pkg::ST_CHECK: begin
        if (status.target_open) begin
          state_next = mbg_pkg::ST_TRY;
        end else if (status.vertical) begin
          state_next = mbg_pkg::ST_MREAD;
        end else begin
          state_next = mbg_pkg::ST_PUSH;
        end
      end
      mbg_pkg::ST_MREAD:  state_next = mbg_pkg::ST_MWRITE;
      mbg_pkg::ST_MWRITE: state_next = mbg_pkg::ST_PUSH;
      mbg_pkg::ST_PUSH:   state_next = mbg_pkg::ST_RESULT;
      mbg_pkg::ST_POP: begin
        state_next = status.pop_more ? mbg_pkg::ST_POPLD : mbg_pkg::ST_RESULT;
      end
      mbg_pkg::ST_POPLD: state_next = mbg_pkg::ST_RESULT;
      mbg_pkg::ST_RDBIT: state_next = mbg_pkg::ST_RESULT;
      mbg_pkg::ST_RESULT: begin
        if (status.out_free) state_next = mbg_pkg::ST_IDLE;
      end
      default: state_next = mbg_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      mbg_pkg::ST_INIT: cmd.clr_write = 1'b1;
      mbg_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
      end
      mbg_pkg::ST_DECODE: begin
        if (status.op == mbg_pkg::OP_STEP) begin
          cmd.shuffle = !status.depth_zero && status.need_shuffle;
        end
        if (status.op == mbg_pkg::OP_READ) begin
          cmd.set_wall = status.read_border;
          cmd.rd_cell  = !status.read_border;
        end
      end
      mbg_pkg::ST_CLEAR: begin
        cmd.clr_write  = 1'b1;
        cmd.clr_open   = 1'b1;
        cmd.start_init = status.clr_last;
      end
      mbg_pkg::ST_TRY: begin
        cmd.tried_inc = !status.try_end && !status.target_in;
        cmd.rd_target = !status.try_end && status.target_in;
      end
      mbg_pkg::ST_CHECK: begin
        cmd.tried_inc = status.target_open;
        cmd.wr_target = !status.target_open;
      end
      mbg_pkg::ST_MREAD:  cmd.rd_mid = 1'b1;
      mbg_pkg::ST_MWRITE: cmd.wr_mid = 1'b1;
      mbg_pkg::ST_PUSH:   cmd.push = 1'b1;
      mbg_pkg::ST_POP:    cmd.pop = 1'b1;
      mbg_pkg::ST_POPLD:  cmd.load_top = 1'b1;
      mbg_pkg::ST_RDBIT:  cmd.take_cell = 1'b1;
      mbg_pkg::ST_RESULT: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/mbg_datapath.sv
module mbg_datapath #(
  parameter int MAX_WIDTH  = mbg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [mbg_pkg::S_TDATA_W-1:0]         s_tdata,
  input  logic [mbg_pkg::OP_W-1:0]              s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mbg_pkg::M_TDATA_W-1:0]         m_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mbg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  mbg_pkg::dp_cmd_t                      cmd,
  output mbg_pkg::dp_status_t                   status
);

  localparam int CW        = mbg_pkg::CMP_W;
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int TW        = mbg_pkg::TRIED_W;
  localparam int STACK_CAP = MAX_WIDTH * MAX_HEIGHT / 4;
  localparam int SAW       = $clog2(STACK_CAP);
  localparam int DW        = $clog2(STACK_CAP + 1);
  localparam int FW        = XW + YW + TW;

  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);
  localparam logic [MAX_WIDTH-1:0] BIT0 = MAX_WIDTH'(1);

  // Configuration
  logic [mbg_pkg::GW_W-1:0] grid_width;
  logic [mbg_pkg::GH_W-1:0] grid_height;
  logic [CW-1:0]            uw;
  logic [CW-1:0]            uh;

  // Latched item
  mbg_pkg::op_t               item_op;
  logic [mbg_pkg::CELL_X_W-1:0] item_x;
  logic [mbg_pkg::CELL_Y_W-1:0] item_y;
  logic [mbg_pkg::SWAP_W-1:0]   item_swap [4];
  logic [CW-1:0]              ix;
  logic [CW-1:0]              iy;
  logic                       start_ok;

  // Top frame, depth and direction order
  logic [XW-1:0]  top_x;
  logic [YW-1:0]  top_y;
  logic [TW-1:0]  top_tried;
  logic [DW-1:0]  depth;
  mbg_pkg::dir_t  dir_order [4];
  mbg_pkg::dir_t  shuf [4];
  mbg_pkg::dir_t  dir;

  // Target and middle cells of the direction under test
  logic [CW-1:0] fx, fy, tx, ty, mx, my;

  // Clear sweep
  logic [YW-1:0] clr_row;
  logic          clr_last;

  // Memories
  logic                 map_we;
  logic [YW-1:0]        map_addr;
  logic [MAX_WIDTH-1:0] map_wdata;
  logic [MAX_WIDTH-1:0] map_rdata;
  logic [FW-1:0]        stk_wdata;
  logic [FW-1:0]        stk_rdata;
  logic [SAW-1:0]       stk_waddr;
  logic [SAW-1:0]       stk_raddr;

  // Result under construction
  logic          res_carved;
  logic [CW-1:0] res_x;
  logic [CW-1:0] res_y;
  logic          res_wall;

  assign uw = (CW'(grid_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(grid_width);
  assign uh = (CW'(grid_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(grid_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= mbg_pkg::GW_W'(mbg_pkg::RESET_WIDTH);
      grid_height <= mbg_pkg::GH_W'(mbg_pkg::RESET_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (mbg_pkg::cfg_idx_t'(cfg_index))
        mbg_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[mbg_pkg::GW_W-1:0];
        mbg_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[mbg_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op      <= mbg_pkg::op_t'(s_tuser);
      item_x       <= s_tdata[6:0];
      item_y       <= s_tdata[12:7];
      item_swap[0] <= s_tdata[14:13];
      item_swap[1] <= s_tdata[16:15];
      item_swap[2] <= s_tdata[18:17];
      item_swap[3] <= s_tdata[20:19];
    end
  end

  assign ix       = CW'(item_x);
  assign iy       = CW'(item_y);
  assign start_ok = (ix < uw) && (iy < uh);

  // Four sequential swaps of the shared direction order
  always_comb begin
    mbg_pkg::dir_t tmp;
    shuf = dir_order;
    for (int i = 0; i < 4; i++) begin
      tmp                = shuf[i];
      shuf[i]            = shuf[item_swap[i]];
      shuf[item_swap[i]] = tmp;
    end
  end

  assign dir = dir_order[top_tried[1:0]];
  assign fx  = CW'(top_x);
  assign fy  = CW'(top_y);

  always_comb begin
    tx = fx;
    ty = fy;
    mx = fx;
    my = fy;
    unique case (dir)
      mbg_pkg::DIR_UP: begin
        ty = fy - TWO_C;
        my = fy - ONE_C;
      end
      mbg_pkg::DIR_RIGHT: begin
        tx = fx + TWO_C;
        mx = fx + ONE_C;
      end
      mbg_pkg::DIR_DOWN: begin
        ty = fy + TWO_C;
        my = fy + ONE_C;
      end
      mbg_pkg::DIR_LEFT: begin
        tx = fx - TWO_C;
        mx = fx - ONE_C;
      end
      default: ;
    endcase
  end

  assign clr_last = (clr_row == YW'(MAX_HEIGHT - 1));

  // Clear sweep counter, frame stack bookkeeping and direction order
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      depth     <= '0;
      dir_order <= '{mbg_pkg::DIR_UP, mbg_pkg::DIR_RIGHT, mbg_pkg::DIR_DOWN,
                     mbg_pkg::DIR_LEFT};
    end else begin
      if (cmd.clr_write) begin
        clr_row <= clr_last ? '0 : clr_row + YW'(1);
      end
      if (cmd.shuffle) begin
        dir_order <= shuf;
      end
      if (cmd.start_init) begin
        depth <= start_ok ? DW'(1) : '0;
      end else if (cmd.push) begin
        depth <= depth + DW'(1);
      end else if (cmd.pop) begin
        depth <= depth - DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_init) begin
      top_x     <= XW'(ix);
      top_y     <= YW'(iy);
      top_tried <= '0;
    end else if (cmd.push) begin
      top_x     <= XW'(tx);
      top_y     <= YW'(ty);
      top_tried <= '0;
    end else if (cmd.load_top) begin
      {top_x, top_y, top_tried} <= stk_rdata;
    end else if (cmd.tried_inc) begin
      top_tried <= top_tried + TW'(1);
    end
  end

  // Grid rows: read-modify-write for carving, whole-row writes for the sweep
  always_comb begin
    map_we    = 1'b0;
    map_addr  = clr_row;
    map_wdata = '0;
    if (cmd.clr_write) begin
      map_we = 1'b1;
      if (cmd.clr_open && start_ok && (clr_row == YW'(iy))) begin
        map_wdata = BIT0 << XW'(ix);
      end
    end else if (cmd.wr_target) begin
      map_we    = 1'b1;
      map_addr  = YW'(ty);
      map_wdata = map_rdata | (BIT0 << XW'(tx));
      if (!status.vertical) begin
        map_wdata = map_wdata | (BIT0 << XW'(mx));
      end
    end else if (cmd.wr_mid) begin
      map_we    = 1'b1;
      map_addr  = YW'(my);
      map_wdata = map_rdata | (BIT0 << XW'(mx));
    end else if (cmd.rd_target) begin
      map_addr = YW'(ty);
    end else if (cmd.rd_mid) begin
      map_addr = YW'(my);
    end else if (cmd.rd_cell) begin
      map_addr = YW'(iy);
    end
  end

  mbg_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_addr),
    .wdata (map_wdata),
    .raddr (map_addr),
    .rdata (map_rdata)
  );

  // Frames below the top one live in the stack memory
  assign stk_wdata = {top_x, top_y, top_tried + TW'(1)};
  assign stk_waddr = SAW'(depth - DW'(1));
  assign stk_raddr = SAW'(depth - DW'(2));

  mbg_ram #(
    .WIDTH (FW),
    .DEPTH (STACK_CAP)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_carved <= 1'b0;
      res_x      <= '0;
      res_y      <= '0;
      res_wall   <= 1'b0;
    end else begin
      if (cmd.push) begin
        res_carved <= 1'b1;
        res_x      <= tx;
        res_y      <= ty;
      end
      if (cmd.set_wall) begin
        res_wall <= 1'b1;
      end
      if (cmd.take_cell) begin
        res_wall <= !map_rdata[XW'(ix)];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_wall, (depth == '0), mbg_pkg::CELL_Y_W'(res_y),
                  mbg_pkg::CELL_X_W'(res_x), res_carved};
    end
  end

  always_comb begin
    status              = '0;
    status.op           = item_op;
    status.clr_last     = clr_last;
    status.depth_zero   = (depth == '0);
    status.need_shuffle = (top_tried == '0);
    status.try_end      = top_tried[TW-1] || (depth == DW'(STACK_CAP));
    status.target_in    = (tx != '0) && (tx < uw) && (ty != '0) && (ty < uh);
    status.target_open  = map_rdata[XW'(tx)];
    status.vertical     = (dir == mbg_pkg::DIR_UP) || (dir == mbg_pkg::DIR_DOWN);
    status.pop_more     = (depth > DW'(1));
    status.read_border  = (ix == '0) || (iy == '0) || (ix >= uw) || (iy >= uh) ||
                          (ix + ONE_C == uw) || (iy + ONE_C == uh);
    status.out_free     = !m_tvalid || m_tready;
  end

endmodule

>>> hdl/maze_backtracker_generator.sv
// Maze generator by depth-first backtracking. Send a start item (operation 0) with a cell to
// clear the grid to walls, open that cell and seed the stack; then send step items
// (operation 1), each with four random swap partners, until done_res comes back 1; read
// items (operation 2) return one cell, the border always reading as wall. The block works
// on one item at a time and returns exactly one result item per input item; it holds the
// finished result in an output register, so it is free for the next item while the result
// waits. After reset a clearing sweep writes every grid row once before the first item is
// taken; configuration writes are taken at any time. The work per item is set by the
// single-port grid row memory and the per-direction test loop: a start item clears one
// row per cycle; a step on an empty stack goes straight to its result; a pop tests each
// direction in turn (one that leaves the grid is passed over, one whose target is already
// open costs a row read and a check) and then reloads the frame below, if any; a carve
// reads one row per wall test, reads and writes the middle row for an up or down move and
// writes one stack frame; a read reads the cell's row unless the cell is on the border. An
// item that finishes while the previous result still waits in the output register holds
// until that result is taken. The grid is stored as MAX_HEIGHT rows of MAX_WIDTH bits, and
// the stack holds up to MAX_WIDTH * MAX_HEIGHT / 4 frames, the top one in registers.
module maze_backtracker_generator #(
  parameter int MAX_WIDTH  = mbg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cell_x[6:0], cell_y[12:7], swap_a[14:13], swap_b[16:15], swap_c[18:17],
  // swap_d[20:19], zero fill [23:21]
  input  logic [mbg_pkg::S_TDATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [mbg_pkg::OP_W-1:0]       s_tuser,
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // carved[0], new_x[7:1], new_y[13:8], done_res[14], is_wall[15]
  output logic [mbg_pkg::M_TDATA_W-1:0]  m_tdata,
  // configuration writes: index 0 grid_width, index 1 grid_height
  input  logic                           cfg_wr_en,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbg_pkg::CFG_DATA_W-1:0] cfg_data
);

  mbg_pkg::dp_cmd_t    cmd;
  mbg_pkg::dp_status_t status;

  // Sequence each item: clear sweep, direction tests, carve, push or pop
  mbg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the grid, the frame stack, the direction order and the result register
  mbg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> hdl/mbg_checker.sv
module mbg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mbg_pkg::M_TDATA_W-1:0] m_tdata
);

  // The clearing sweep after reset blocks input
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during the clearing sweep after reset");

  // One item at a time: no input right after an accepted item
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // A carve pushes a frame, so the stack cannot be empty and it is no read
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[14] && !m_tdata[15])
    else $error("carved result reports an empty stack or a wall");

endmodule

bind maze_backtracker_generator mbg_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
